@@ src/ldr_pkg.sv @@
// ----------------------------------------------------------------------------
// Lens distortion remap address: shared package
// Widths, register codes, saturating arithmetic and the per-item record
// that travels down the polynomial pipeline.
// ----------------------------------------------------------------------------
package ldr_pkg;

    // Internal fixed-point word: signed, NORM_FRAC fraction bits.
    localparam int DATA_W             = 52;
    localparam int NORM_FRAC          = 24;
    localparam int PIX_FRAC           = 4;
    localparam int FOCAL_W            = 16;
    localparam int MUL_LAT            = 4;
    localparam int CFG_W              = 32;
    localparam int NUM_REGS           = 8;
    localparam int REG_IDX_W          = 3;
    localparam int DEF_MAX_DIM_BITS   = 12;
    localparam int DEF_COEF_FRAC_BITS = 28;

    typedef logic signed [DATA_W-1:0] t_data;

    // Saturation limit 2^50 - 1, one bit wider than t_data for sum checks.
    localparam logic signed [DATA_W:0] SAT_LIM = 53'sh3_FFFF_FFFF_FFFF;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_K1    = 3'd0,
        REG_K2    = 3'd1,
        REG_K3    = 3'd2,
        REG_P1    = 3'd3,
        REG_P2    = 3'd4,
        REG_FOCAL = 3'd5,
        REG_CENTR = 3'd6,
        REG_SIZE  = 3'd7
    } t_reg_idx;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h1000_1000, 32'h0000_0000, 32'h1000_1000
    };

    // Values carried alongside the multipliers from level to level.
    typedef struct packed {
        t_data x;
        t_data y;
        t_data xy;
        t_data r2;
        t_data r4;
        t_data r6;
        t_data ex;
        t_data ey;
        t_data poly;
        t_data hx;
        t_data hy;
        t_data vx;
        t_data vy;
        t_data xd;
        t_data yd;
    } t_carry;

    // Sum of two words, clamped to +-(2^50 - 1).
    function automatic t_data sat_add(input t_data a, input t_data b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s > SAT_LIM) begin
            return t_data'(SAT_LIM);
        end else if (s < -SAT_LIM) begin
            return t_data'(-SAT_LIM);
        end
        return t_data'(s);
    endfunction

    function automatic t_data coef_ext(input logic [CFG_W-1:0] r);
        return t_data'({{(DATA_W-CFG_W){r[CFG_W-1]}}, r});
    endfunction

    function automatic t_data focal_ext(input logic [FOCAL_W-1:0] f);
        return t_data'({{(DATA_W-FOCAL_W){1'b0}}, f});
    endfunction

endpackage

@@ src/ldr_div.sv @@
// ----------------------------------------------------------------------------
// Lens distortion remap address: pipelined divider
// Restoring division, one quotient bit per register stage, computing
// (magnitude << FRAC) / denominator with the quotient truncated.
// ----------------------------------------------------------------------------
module ldr_div #(
    parameter int MAG_W = 16,
    parameter int DEN_W = 16,
    parameter int FRAC  = 24
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [MAG_W-1:0]      i_mag,
    input  logic                  i_neg,
    input  logic [DEN_W-1:0]      i_den,
    output logic [MAG_W+FRAC-1:0] o_quo,
    output logic                  o_neg
);
    localparam int Q_W = MAG_W + FRAC;

    // Each stage shifts one dividend bit out of the top of r_acc and the
    // new quotient bit into the bottom.
    logic [Q_W-1:0]   r_acc [Q_W];
    logic [DEN_W-1:0] r_rem [Q_W];
    logic             r_neg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [Q_W-1:0]   w_acc;
        logic [DEN_W-1:0] w_rem;
        logic             w_neg;
        logic [DEN_W:0]   w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_acc = {i_mag, {FRAC{1'b0}}};
            assign w_rem = '0;
            assign w_neg = i_neg;
        end else begin : g_next
            assign w_acc = r_acc[k-1];
            assign w_rem = r_rem[k-1];
            assign w_neg = r_neg[k-1];
        end

        assign w_trial = {w_rem, w_acc[Q_W-1]};
        assign w_ge    = w_trial >= {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= {w_acc[Q_W-2:0], w_ge};
                r_rem[k] <= w_ge ? DEN_W'(w_trial - {1'b0, i_den}) : w_trial[DEN_W-1:0];
                r_neg[k] <= w_neg;
            end
        end
    end

    assign o_quo = r_acc[Q_W-1];
    assign o_neg = r_neg[Q_W-1];

endmodule

@@ src/ldr_mulq.sv @@
// ----------------------------------------------------------------------------
// Lens distortion remap address: pipelined fixed-point multiplier
// Sign-magnitude product shifted right by SHIFT with the magnitude truncated,
// then clamped to +-(2^50 - 1). Four register stages.
// ----------------------------------------------------------------------------
module ldr_mulq #(
    parameter int SHIFT = 24
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  ldr_pkg::t_data i_a,
    input  ldr_pkg::t_data i_b,
    output ldr_pkg::t_data o_p
);
    import ldr_pkg::*;

    localparam int MAG_W  = DATA_W - 1;
    localparam int LO_W   = (MAG_W + 1) / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PROD_W = 2 * MAG_W;
    localparam int RES_W  = DATA_W - 2;

    t_data                w_abs_a;
    t_data                w_abs_b;
    logic [PROD_W-1:0]    w_sum;
    logic [PROD_W-1:0]    w_sh;
    logic [RES_W-1:0]     w_mag;

    logic [MAG_W-1:0]     r_ua;
    logic [MAG_W-1:0]     r_ub;
    logic [2*LO_W-1:0]    r_p00;
    logic [LO_W+HI_W-1:0] r_p01;
    logic [LO_W+HI_W-1:0] r_p10;
    logic [2*HI_W-1:0]    r_p11;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_neg1;
    logic                 r_neg2;
    logic                 r_neg3;
    t_data                r_p;

    assign w_abs_a = i_a[DATA_W-1] ? -i_a : i_a;
    assign w_abs_b = i_b[DATA_W-1] ? -i_b : i_b;

    assign w_sum = PROD_W'(r_p00)
                 + (PROD_W'(r_p01) << LO_W)
                 + (PROD_W'(r_p10) << LO_W)
                 + (PROD_W'(r_p11) << (2 * LO_W));

    assign w_sh  = r_prod >> SHIFT;
    assign w_mag = (|w_sh[PROD_W-1:RES_W]) ? '1 : w_sh[RES_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ua   <= w_abs_a[MAG_W-1:0];
            r_ub   <= w_abs_b[MAG_W-1:0];
            r_neg1 <= i_a[DATA_W-1] ^ i_b[DATA_W-1];

            r_p00  <= r_ua[LO_W-1:0] * r_ub[LO_W-1:0];
            r_p01  <= r_ua[LO_W-1:0] * r_ub[MAG_W-1:LO_W];
            r_p10  <= r_ua[MAG_W-1:LO_W] * r_ub[LO_W-1:0];
            r_p11  <= r_ua[MAG_W-1:LO_W] * r_ub[MAG_W-1:LO_W];
            r_neg2 <= r_neg1;

            r_prod <= w_sum;
            r_neg3 <= r_neg2;

            r_p    <= r_neg3 ? -t_data'({2'b00, w_mag}) : t_data'({2'b00, w_mag});
        end
    end

    assign o_p = r_p;

endmodule

@@ src/lens_distortion_remap_address_unit.sv @@
// ----------------------------------------------------------------------------
// Lens distortion remap address unit
// Brown-Conrady inverse-map address generator: for each output pixel it gives
// the source pixel to fetch and whether that pixel lies inside the image.
// ----------------------------------------------------------------------------
// Usage:
//   Output pixel coordinates enter on the s_axis channel, one transaction per
//   pixel; the matching source coordinates leave on m_axis in the same order,
//   with m_axis_tuser high when the source pixel is inside the image. When it
//   is not (or a focal length is zero) the coordinates are zero and the
//   pixel should be painted black.
//   The block accepts one transaction per clock while s_axis_tready is high.
//   The one-bit-per-stage divider that normalizes the coordinates and the
//   six levels of four-stage multipliers and their adders make up most of
//   the pipeline. Coefficients, focal lengths, principal point and image
//   size are to be written through the i_cfg port only while no transaction
//   is in flight; the block itself does not enforce this.
//   Reset restores the register defaults and empties the pipeline.
//   When the receiver stalls, the finished result is held in the output
//   register and the next one drops into a skid register; s_axis_tready
//   falls only once the skid register is full and the whole pipeline then
//   freezes until the receiver takes a result.
// ----------------------------------------------------------------------------
module lens_distortion_remap_address_unit #(
    parameter int MAX_DIM_BITS   = ldr_pkg::DEF_MAX_DIM_BITS,
    parameter int COEF_FRAC_BITS = ldr_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [ldr_pkg::REG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ldr_pkg::CFG_W-1:0]            i_cfg_wdata,
    // Input channel: tdata = {out_col, out_row} (out_row in the lowest bits).
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((2*MAX_DIM_BITS+7)/8)*8-1:0]  s_axis_tdata,
    // Output channel: tdata = {src_col, src_row} (src_row in the lowest bits).
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((2*MAX_DIM_BITS+7)/8)*8-1:0]  m_axis_tdata,
    // tuser = in_bounds.
    output logic                                 m_axis_tuser
);
    import ldr_pkg::*;

    localparam int M       = MAX_DIM_BITS;
    localparam int BUS_W   = ((2 * M + 7) / 8) * 8;
    localparam int PIX_W   = M + PIX_FRAC;
    localparam int MAG_W   = (PIX_W > FOCAL_W) ? PIX_W : FOCAL_W;
    localparam int Q_W     = MAG_W + NORM_FRAC;
    localparam int LVL     = 5;
    localparam int LAT     = Q_W + 6 + 6 * (MUL_LAT + 1);
    localparam int PC_W    = DATA_W - NORM_FRAC + 1;
    localparam t_data ONE_Q    = t_data'(64'd1 << NORM_FRAC);
    localparam t_data CEIL_ADD = t_data'((64'd1 << NORM_FRAC) - 64'd1);

    typedef struct packed {
        logic         inb;
        logic [M-1:0] row;
        logic [M-1:0] col;
    } t_res;

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0] r_cfg [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    logic [FOCAL_W-1:0] w_fx, w_fy, w_cx, w_cy, w_cols, w_rows;
    assign w_fx   = r_cfg[REG_FOCAL][31:16];
    assign w_fy   = r_cfg[REG_FOCAL][15:0];
    assign w_cx   = r_cfg[REG_CENTR][31:16];
    assign w_cy   = r_cfg[REG_CENTR][15:0];
    assign w_cols = r_cfg[REG_SIZE][31:16];
    assign w_rows = r_cfg[REG_SIZE][15:0];

    // The whole pipeline steps together; only a full skid register stops it.
    logic w_en;
    logic r_skid_valid;
    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    // Valid bits, one per pipeline stage.
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // ------------------------------------------------- input and normalizing
    logic [M-1:0] r_in_row, r_in_col;
    logic signed [MAG_W:0] w_num_x, w_num_y;
    logic signed [MAG_W:0] w_abs_x, w_abs_y;
    logic [MAG_W-1:0] r_mag_x, r_mag_y;
    logic r_neg_x, r_neg_y;

    assign w_num_x = $signed({1'b0, MAG_W'({r_in_col, {PIX_FRAC{1'b0}}})})
                   - $signed({1'b0, MAG_W'(w_cx)});
    assign w_num_y = $signed({1'b0, MAG_W'({r_in_row, {PIX_FRAC{1'b0}}})})
                   - $signed({1'b0, MAG_W'(w_cy)});
    assign w_abs_x = w_num_x[MAG_W] ? -w_num_x : w_num_x;
    assign w_abs_y = w_num_y[MAG_W] ? -w_num_y : w_num_y;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_row <= s_axis_tdata[M-1:0];
            r_in_col <= s_axis_tdata[2*M-1:M];
            r_mag_x  <= w_abs_x[MAG_W-1:0];
            r_mag_y  <= w_abs_y[MAG_W-1:0];
            r_neg_x  <= w_num_x[MAG_W];
            r_neg_y  <= w_num_y[MAG_W];
        end
    end

    logic [Q_W-1:0] w_qx, w_qy;
    logic w_qx_neg, w_qy_neg;

    ldr_div #(.MAG_W(MAG_W), .DEN_W(FOCAL_W), .FRAC(NORM_FRAC)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (r_mag_x),
        .i_neg (r_neg_x),
        .i_den (w_fx),
        .o_quo (w_qx),
        .o_neg (w_qx_neg)
    );

    ldr_div #(.MAG_W(MAG_W), .DEN_W(FOCAL_W), .FRAC(NORM_FRAC)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (r_mag_y),
        .i_neg (r_neg_y),
        .i_den (w_fy),
        .o_quo (w_qy),
        .o_neg (w_qy_neg)
    );

    // Signed normalized coordinates enter the carry record.
    t_carry r_l0, n_l0;
    always_comb begin
        n_l0   = '0;
        n_l0.x = w_qx_neg ? -t_data'({{(DATA_W-Q_W){1'b0}}, w_qx})
                          :  t_data'({{(DATA_W-Q_W){1'b0}}, w_qx});
        n_l0.y = w_qy_neg ? -t_data'({{(DATA_W-Q_W){1'b0}}, w_qy})
                          :  t_data'({{(DATA_W-Q_W){1'b0}}, w_qy});
    end

    // ---------------------------------------------------- polynomial levels
    // Each level runs its multipliers while the carry record waits in a
    // delay line of equal length, then one adder stage merges the products.
    t_carry r_l1, r_l2, r_l3, r_l4, r_l5;
    t_carry n_l1, n_l2, n_l3, n_l4, n_l5;
    t_carry r_dly [LVL][MUL_LAT];
    t_carry n_dly_in [LVL];
    t_carry w_d1, w_d2, w_d3, w_d4, w_d5;

    assign w_d1 = r_dly[0][MUL_LAT-1];
    assign w_d2 = r_dly[1][MUL_LAT-1];
    assign w_d3 = r_dly[2][MUL_LAT-1];
    assign w_d4 = r_dly[3][MUL_LAT-1];
    assign w_d5 = r_dly[4][MUL_LAT-1];

    t_data w_x2, w_y2, w_xy;
    t_data w_r4, w_t1, w_u1, w_u2;
    t_data w_r6, w_t2, w_vx, w_vy;
    t_data w_t3;
    t_data w_mx, w_my;
    t_data w_mc, w_mr;

    // Level 1: squares and cross product.
    ldr_mulq #(.SHIFT(NORM_FRAC)) u_mul_x2 (.i_clk(i_clk), .i_en(w_en),
        .i_a(r_l0.x), .i_b(r_l0.x), .o_p(w_x2));
    ldr_mulq #(.SHIFT(NORM_FRAC)) u_mul_y2 (.i_clk(i_clk), .i_en(w_en),
        .i_a(r_l0.y), .i_b(r_l0.y), .o_p(w_y2));
    ldr_mulq #(.SHIFT(NORM_FRAC)) u_mul_xy (.i_clk(i_clk), .i_en(w_en),
        .i_a(r_l0.x), .i_b(r_l0.y), .o_p(w_xy));

    // Level 2: r^4, the k1 term and both tangential cross terms.
    ldr_mulq #(.SHIFT(NORM_FRAC)) u_mul_r4 (.i_clk(i_clk), .i_en(w_en),
        .i_a(r_l1.r2), .i_b(r_l1.r2), .o_p(w_r4));
    ldr_mulq #(.SHIFT(COEF_FRAC_BITS)) u_mul_t1 (.i_clk(i_clk), .i_en(w_en),
        .i_a(coef_ext(r_cfg[REG_K1])), .i_b(r_l1.r2), .o_p(w_t1));
    ldr_mulq #(.SHIFT(COEF_FRAC_BITS)) u_mul_u1 (.i_clk(i_clk), .i_en(w_en),
        .i_a(coef_ext(r_cfg[REG_P1])), .i_b(r_l1.xy), .o_p(w_u1));
    ldr_mulq #(.SHIFT(COEF_FRAC_BITS)) u_mul_u2 (.i_clk(i_clk), .i_en(w_en),
        .i_a(coef_ext(r_cfg[REG_P2])), .i_b(r_l1.xy), .o_p(w_u2));

    // Level 3: r^6, the k2 term and the tangential square terms.
    ldr_mulq #(.SHIFT(NORM_FRAC)) u_mul_r6 (.i_clk(i_clk), .i_en(w_en),
        .i_a(r_l2.r4), .i_b(r_l2.r2), .o_p(w_r6));
    ldr_mulq #(.SHIFT(COEF_FRAC_BITS)) u_mul_t2 (.i_clk(i_clk), .i_en(w_en),
        .i_a(coef_ext(r_cfg[REG_K2])), .i_b(r_l2.r4), .o_p(w_t2));
    ldr_mulq #(.SHIFT(COEF_FRAC_BITS)) u_mul_vx (.i_clk(i_clk), .i_en(w_en),
        .i_a(coef_ext(r_cfg[REG_P2])), .i_b(r_l2.ex), .o_p(w_vx));
    ldr_mulq #(.SHIFT(COEF_FRAC_BITS)) u_mul_vy (.i_clk(i_clk), .i_en(w_en),
        .i_a(coef_ext(r_cfg[REG_P1])), .i_b(r_l2.ey), .o_p(w_vy));

    // Level 4: the k3 term.
    ldr_mulq #(.SHIFT(COEF_FRAC_BITS)) u_mul_t3 (.i_clk(i_clk), .i_en(w_en),
        .i_a(coef_ext(r_cfg[REG_K3])), .i_b(r_l3.r6), .o_p(w_t3));

    // Level 5: radial scaling of x and y.
    ldr_mulq #(.SHIFT(NORM_FRAC)) u_mul_mx (.i_clk(i_clk), .i_en(w_en),
        .i_a(r_l4.x), .i_b(r_l4.poly), .o_p(w_mx));
    ldr_mulq #(.SHIFT(NORM_FRAC)) u_mul_my (.i_clk(i_clk), .i_en(w_en),
        .i_a(r_l4.y), .i_b(r_l4.poly), .o_p(w_my));

    always_comb begin
        n_dly_in[0]    = r_l0;
        n_dly_in[1]    = r_l1;
        // The doubled squares from level 1 become r2 + 2 x^2 and r2 + 2 y^2.
        n_dly_in[1].ex = sat_add(r_l1.r2, r_l1.ex);
        n_dly_in[1].ey = sat_add(r_l1.r2, r_l1.ey);
        n_dly_in[2]    = r_l2;
        n_dly_in[3]    = r_l3;
        n_dly_in[4]    = r_l4;

        n_l1    = w_d1;
        n_l1.xy = w_xy;
        n_l1.r2 = sat_add(w_x2, w_y2);
        n_l1.ex = sat_add(w_x2, w_x2);
        n_l1.ey = sat_add(w_y2, w_y2);

        n_l2      = w_d2;
        n_l2.r4   = w_r4;
        n_l2.poly = sat_add(ONE_Q, w_t1);
        n_l2.hx   = sat_add(w_u1, w_u1);
        n_l2.hy   = sat_add(w_u2, w_u2);

        n_l3      = w_d3;
        n_l3.r6   = w_r6;
        n_l3.poly = sat_add(w_d3.poly, w_t2);
        n_l3.vx   = w_vx;
        n_l3.vy   = w_vy;

        n_l4      = w_d4;
        n_l4.poly = sat_add(w_d4.poly, w_t3);

        n_l5    = w_d5;
        n_l5.xd = sat_add(w_mx, w_d5.hx);
        n_l5.yd = sat_add(w_my, w_d5.vy);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l0 <= n_l0;
            for (int l = 0; l < LVL; l++) begin
                r_dly[l][0] <= n_dly_in[l];
                for (int i = 1; i < MUL_LAT; i++) begin
                    r_dly[l][i] <= r_dly[l][i-1];
                end
            end
            r_l1 <= n_l1;
            r_l2 <= n_l2;
            r_l3 <= n_l3;
            r_l4 <= n_l4;
            r_l5 <= n_l5;
        end
    end

    // ------------------------------------------------- back to pixel units
    t_data r_xd, r_yd;
    t_data r_vc, r_vr;
    logic signed [PC_W-1:0] r_pc, r_pr;
    t_data w_pc_full, w_pr_full;

    ldr_mulq #(.SHIFT(PIX_FRAC)) u_mul_pc (.i_clk(i_clk), .i_en(w_en),
        .i_a(focal_ext(w_fx)), .i_b(r_xd), .o_p(w_mc));
    ldr_mulq #(.SHIFT(PIX_FRAC)) u_mul_pr (.i_clk(i_clk), .i_en(w_en),
        .i_a(focal_ext(w_fy)), .i_b(r_yd), .o_p(w_mr));

    // Round up to an integer pixel: ceil for positive values, and a negative
    // value rounds toward zero.
    assign w_pc_full = r_vc[DATA_W-1] ? -((-r_vc) >>> NORM_FRAC)
                                      : ((r_vc + CEIL_ADD) >>> NORM_FRAC);
    assign w_pr_full = r_vr[DATA_W-1] ? -((-r_vr) >>> NORM_FRAC)
                                      : ((r_vr + CEIL_ADD) >>> NORM_FRAC);

    // Bounds check against the image size and the coordinate width.
    logic w_ok_c, w_ok_r, w_ok;
    t_res r_bnd, n_bnd;

    assign w_ok_c = !r_pc[PC_W-1]
                 && (r_pc[PC_W-2:0] < (PC_W-1)'(w_cols))
                 && (r_pc[PC_W-2:M] == '0);
    assign w_ok_r = !r_pr[PC_W-1]
                 && (r_pr[PC_W-2:0] < (PC_W-1)'(w_rows))
                 && (r_pr[PC_W-2:M] == '0);
    assign w_ok   = w_ok_c && w_ok_r && (w_fx != '0) && (w_fy != '0);

    always_comb begin
        n_bnd.inb = w_ok;
        n_bnd.row = w_ok ? r_pr[M-1:0] : '0;
        n_bnd.col = w_ok ? r_pc[M-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xd  <= sat_add(r_l5.xd, r_l5.vx);
            r_yd  <= sat_add(r_l5.yd, r_l5.hy);
            r_vc  <= sat_add(focal_ext(w_cx) <<< (NORM_FRAC - PIX_FRAC), w_mc);
            r_vr  <= sat_add(focal_ext(w_cy) <<< (NORM_FRAC - PIX_FRAC), w_mr);
            r_pc  <= w_pc_full[PC_W-1:0];
            r_pr  <= w_pr_full[PC_W-1:0];
            r_bnd <= n_bnd;
        end
    end

    // ------------------------------------------------ output and skid stage
    logic r_out_valid;
    t_res r_out, r_skid;
    logic w_free;

    assign w_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_vld[LAT-1]) begin
            if (w_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_free) begin
                r_out <= r_skid;
            end
        end else if (r_vld[LAT-1]) begin
            if (w_free) begin
                r_out <= r_bnd;
            end else begin
                r_skid <= r_bnd;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.inb;
    assign m_axis_tdata  = BUS_W'({r_out.col, r_out.row});

    // ----------------------------------------------------------- assertions
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output is empty");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && !r_skid_valid && r_out_valid && !m_axis_tready)
        |=> r_skid_valid)
        else $error("result leaving the pipeline during a stall was dropped");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && m_axis_tready) |=> !r_skid_valid)
        else $error("skid register did not drain when the receiver was ready");

    a_black_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("out-of-bounds result carries nonzero coordinates");

endmodule
